// File: design/mtt_pkg.sv
// ============================================================================
// mtt_pkg: shared types and codes for the MIDI tempo tracker
// Event kinds, usage codes, register indexes and divider control types.
// ============================================================================
package mtt_pkg;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_NOTE  = 2'd1;
    localparam logic [1:0] KIND_CC    = 2'd2;

    localparam logic [6:0] PEDAL_CONTROLLER = 7'd64;
    localparam logic [6:0] PEDAL_PRESSED    = 7'd127;

    localparam logic [1:0] USE_IGNORED = 2'd0;
    localparam logic [1:0] USE_FIRST   = 2'd1;
    localparam logic [1:0] USE_NOTE    = 2'd2;
    localparam logic [1:0] USE_PEDAL   = 2'd3;

    localparam logic [2:0] REG_MIN_GAP     = 3'd0;
    localparam logic [2:0] REG_LOWER       = 3'd1;
    localparam logic [2:0] REG_UPPER       = 3'd2;
    localparam logic [2:0] REG_NOTE_LIMIT  = 3'd3;
    localparam logic [2:0] REG_PEDAL_LIMIT = 3'd4;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

// File: design/mtt_div.sv
// ============================================================================
// mtt_div: restoring divider, one quotient bit per cycle
// Divides an NB-bit dividend by a DB-bit divisor; quotient truncated.
// ============================================================================
module mtt_div #(
    parameter int NB = 40,
    parameter int DB = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NB-1:0] dividend,
    input  logic [DB-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [NB-1:0] quotient
);
    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0] q_reg;
    logic [DB:0]   r_reg;
    logic [DB-1:0] d_reg;
    logic [CB-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DB:0]   shifted;
    logic [DB:0]   diff;

    assign shifted = {r_reg[DB-1:0], q_reg[NB-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(NB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CB'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DB])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[NB-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[NB-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// File: design/midi_tempo_tracker.sv
// ============================================================================
// midi_tempo_tracker: note and sustain-pedal tempo follower
// Sums deltas per kind, judges intervals against a ratio window around the
// running means, pairs half intervals, folds eighth notes, clears on misses.
// ============================================================================
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in      | in  | in_valid/in_stall  | event_kind controller ctrl_value delta_time
//  out     | out | out_valid/out_stall| note_period pedal_period note_count event_use
//  cfg     | in  | cfg_valid/cfg_ready| cfg_index cfg_data
//
//  Steps from accept to next accept: an ignored or dropped event passes
//  through result and idle. A judged interval that changes no mean passes
//  through two window products on the shared multiplier, judgment, result
//  and idle. A mean update adds a bit-serial divide; a fold adds a second
//  product pair, its judgment and another divide. Reset clears all state at
//  once, no sweep. The result sits in an output register; in_stall is high
//  from acceptance until the result transfer.
// ============================================================================
module midi_tempo_tracker #(
    parameter int TIME_BITS      = 24,
    parameter int COUNT_BITS     = 16,
    parameter int FOLD_MIN_COUNT = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            event_kind,
    input  logic [6:0]            controller,
    input  logic [6:0]            ctrl_value,
    input  logic [TIME_BITS-1:0]  delta_time,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TIME_BITS-1:0]  note_period,
    output logic [TIME_BITS-1:0]  pedal_period,
    output logic [COUNT_BITS-1:0] note_count,
    output logic [1:0]            event_use,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [23:0]           cfg_data
);
    localparam int TB  = TIME_BITS;
    localparam int CB  = COUNT_BITS;
    localparam int SB  = TB + CB;
    localparam int PB  = SB + 16;       // product width: total*ratio*8 fits
    localparam logic [TB-1:0] TMAX = {TB{1'b1}};
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};
    localparam logic [SB-1:0] SMAX = {SB{1'b1}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M0    = 4'd2;  // product m*lower
    localparam logic [3:0] S_M1    = 4'd3;  // product m*upper
    localparam logic [3:0] S_JUDGE = 4'd4;
    localparam logic [3:0] S_F0    = 4'd5;
    localparam logic [3:0] S_F1    = 4'd6;
    localparam logic [3:0] S_FJ    = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DWAIT = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] st_reg;

    // configuration
    logic [TB-1:0] min_gap_reg;
    logic [11:0]   lo_reg, hi_reg;
    logic [7:0]    nlim_reg, plim_reg;

    // tracker state
    logic          fnote_reg, fpedal_reg;
    logic [TB-1:0] ngap_reg, pgap_reg;
    logic [SB-1:0] ntot_reg, ptot_reg;
    logic [CB-1:0] nent_reg, pent_reg;
    logic [TB-1:0] rec0_reg, rec1_reg, rec2_reg;
    logic [TB-1:0] nmean_reg, pmean_reg, half_reg;
    logic [7:0]    nmiss_reg, pmiss_reg;

    // per-item work
    logic          is_pedal_reg;  // judged kind
    logic [TB-1:0] d_reg;
    logic [PB-1:0] plo_reg, phi_reg;
    logic [1:0]    use_reg;
    logic          div_pedal_reg;
    logic          ov_reg;

    // shared multiplier: a (mean, up to TB bits) times a 15-bit factor
    logic [TB-1:0] mul_a;
    logic [14:0]   mul_b;
    logic [TB+14:0] mul_w;
    logic [PB-1:0] mul_p;
    logic [TB-1:0] cur_mean;
    logic          fsel;
    assign cur_mean = is_pedal_reg ? pmean_reg : nmean_reg;
    assign fsel     = (st_reg == S_F0) || (st_reg == S_F1);
    always_comb
    begin
        mul_a = fsel ? nmean_reg : cur_mean;
        if (st_reg == S_M0 || st_reg == S_F0)
            mul_b = fsel ? {lo_reg, 3'b000} : {3'b000, lo_reg};
        else
            mul_b = fsel ? {hi_reg, 3'b000} : {3'b000, hi_reg};
    end
    assign mul_w = mul_a * mul_b;
    assign mul_p = PB'(mul_w);

    // divider
    logic          dv_start, dv_busy, dv_done;
    logic [SB-1:0] dv_q;
    mtt_div #(.NB(SB), .DB(CB)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start),
        .dividend(div_pedal_reg ? ptot_reg : ntot_reg),
        .divisor(div_pedal_reg ? pent_reg : nent_reg),
        .busy(dv_busy), .done(dv_done), .quotient(dv_q));
    assign dv_start = (st_reg == S_DIV);

    // decode of the accepted item
    logic          note_on, pedal_on;
    logic [TB:0]   nsum_w, psum_w;
    logic [TB-1:0] nsum, psum;
    assign note_on  = (event_kind == mtt_pkg::KIND_NOTE);
    assign pedal_on = (event_kind == mtt_pkg::KIND_CC) &&
                      (controller == mtt_pkg::PEDAL_CONTROLLER) &&
                      (ctrl_value == mtt_pkg::PEDAL_PRESSED);
    assign nsum_w = {1'b0, ngap_reg} + {1'b0, delta_time};
    assign psum_w = {1'b0, pgap_reg} + {1'b0, delta_time};
    assign nsum   = fnote_reg ? ngap_reg : (nsum_w[TB] ? TMAX : nsum_w[TB-1:0]);
    assign psum   = fpedal_reg ? pgap_reg : (psum_w[TB] ? TMAX : psum_w[TB-1:0]);

    // window tests
    logic [PB-1:0] x1, x2;
    logic          in_w1, in_w2, empty;
    assign x1    = PB'(d_reg) << 8;
    assign x2    = PB'(d_reg) << 9;
    assign in_w1 = (x1 > plo_reg) && (x1 < phi_reg);
    assign in_w2 = (x2 > plo_reg) && (x2 < phi_reg);
    assign empty = is_pedal_reg ? (pent_reg == '0) : (nent_reg == '0);

    // adders for add paths
    logic [TB:0]   hsum_w;
    logic [TB-1:0] add_v;
    logic [SB:0]   ntot_w, ptot_w;
    logic [SB-1:0] ntot_add, ptot_add;
    logic [CB-1:0] nent_add, pent_add;
    assign hsum_w   = {1'b0, half_reg} + {1'b0, d_reg};
    assign add_v    = (!(empty || in_w1)) ? (hsum_w[TB] ? TMAX : hsum_w[TB-1:0]) : d_reg;
    assign ntot_w   = {1'b0, ntot_reg} + {{(CB+1){1'b0}}, add_v};
    assign ptot_w   = {1'b0, ptot_reg} + {{(CB+1){1'b0}}, d_reg};
    assign ntot_add = ntot_w[SB] ? SMAX : ntot_w[SB-1:0];
    assign ptot_add = ptot_w[SB] ? SMAX : ptot_w[SB-1:0];
    assign nent_add = (nent_reg == CMAX) ? CMAX : nent_reg + 1'b1;
    assign pent_add = (pent_reg == CMAX) ? CMAX : pent_reg + 1'b1;

    logic [8:0] nmiss_inc, pmiss_inc;
    assign nmiss_inc = {1'b0, nmiss_reg} + 9'd1;
    assign pmiss_inc = {1'b0, pmiss_reg} + 9'd1;

    // fold
    logic [PB-1:0] pp;
    logic [TB:0]   f12_w, f01_w;
    assign pp    = PB'(pmean_reg) << 8;
    assign f12_w = {1'b0, rec1_reg} + {1'b0, rec2_reg};
    assign f01_w = {1'b0, rec0_reg} + {1'b0, rec1_reg};

    assign in_stall  = (st_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (st_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            min_gap_reg <= '0;
            lo_reg      <= 12'd205;
            hi_reg      <= 12'd307;
            nlim_reg    <= 8'd10;
            plim_reg    <= 8'd2;
            fnote_reg   <= 1'b1;
            fpedal_reg  <= 1'b1;
            ngap_reg    <= '0;
            pgap_reg    <= '0;
            ntot_reg    <= '0;
            ptot_reg    <= '0;
            nent_reg    <= '0;
            pent_reg    <= '0;
            rec0_reg    <= '0;
            rec1_reg    <= '0;
            rec2_reg    <= '0;
            nmean_reg   <= '0;
            pmean_reg   <= '0;
            half_reg    <= '0;
            nmiss_reg   <= '0;
            pmiss_reg   <= '0;
            use_reg     <= mtt_pkg::USE_IGNORED;
            is_pedal_reg  <= 1'b0;
            div_pedal_reg <= 1'b0;
            d_reg       <= '0;
            plo_reg     <= '0;
            phi_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    mtt_pkg::REG_MIN_GAP:     min_gap_reg <= TB'(cfg_data);
                    mtt_pkg::REG_LOWER:       lo_reg      <= cfg_data[11:0];
                    mtt_pkg::REG_UPPER:       hi_reg      <= cfg_data[11:0];
                    mtt_pkg::REG_NOTE_LIMIT:  nlim_reg    <= cfg_data[7:0];
                    mtt_pkg::REG_PEDAL_LIMIT: plim_reg    <= cfg_data[7:0];
                    default: ;
                endcase
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        st_reg <= S_OUT;
                        if (fnote_reg && note_on)
                        begin
                            fnote_reg <= 1'b0;
                            use_reg   <= mtt_pkg::USE_FIRST;
                        end
                        else if (fpedal_reg && pedal_on)
                        begin
                            fpedal_reg <= 1'b0;
                            use_reg    <= mtt_pkg::USE_FIRST;
                        end
                        else
                        begin
                            ngap_reg <= nsum;
                            pgap_reg <= psum;
                            use_reg  <= mtt_pkg::USE_IGNORED;
                            if (note_on && nsum > min_gap_reg)
                            begin
                                ngap_reg     <= '0;
                                d_reg        <= nsum;
                                is_pedal_reg <= 1'b0;
                                use_reg      <= mtt_pkg::USE_NOTE;
                                st_reg       <= S_M0;
                            end
                            else if (pedal_on)
                            begin
                                pgap_reg     <= '0;
                                d_reg        <= psum;
                                is_pedal_reg <= 1'b1;
                                use_reg      <= mtt_pkg::USE_PEDAL;
                                st_reg       <= S_M0;
                            end
                        end
                    end
                end
                S_M0:
                begin
                    plo_reg <= mul_p;
                    st_reg  <= S_M1;
                end
                S_M1:
                begin
                    phi_reg <= mul_p;
                    st_reg  <= S_JUDGE;
                end
                S_JUDGE:
                begin
                    st_reg <= S_OUT;
                    if (is_pedal_reg)
                    begin
                        if (empty || in_w1)
                        begin
                            ptot_reg      <= ptot_add;
                            pent_reg      <= pent_add;
                            pmiss_reg     <= '0;
                            div_pedal_reg <= 1'b1;
                            st_reg        <= S_DIV;
                        end
                        else if (pmiss_inc > {1'b0, plim_reg})
                        begin
                            pent_reg  <= '0;
                            ptot_reg  <= '0;
                            pmean_reg <= '0;
                            pmiss_reg <= '0;
                        end
                        else
                            pmiss_reg <= pmiss_inc[7:0];
                    end
                    else if (empty || in_w1 || (in_w2 && half_reg != '0))
                    begin
                        if (!(empty || in_w1))
                            half_reg <= '0;
                        rec2_reg      <= rec1_reg;
                        rec1_reg      <= rec0_reg;
                        rec0_reg      <= add_v;
                        ntot_reg      <= ntot_add;
                        nent_reg      <= nent_add;
                        nmiss_reg     <= '0;
                        div_pedal_reg <= 1'b0;
                        // fold check only on the direct add path
                        ov_reg        <= empty || in_w1;
                        st_reg        <= S_DIV;
                    end
                    else if (in_w2)
                        half_reg <= d_reg;
                    else if (nmiss_inc > {1'b0, nlim_reg})
                    begin
                        nent_reg  <= '0;
                        ntot_reg  <= '0;
                        nmean_reg <= '0;
                        nmiss_reg <= '0;
                    end
                    else
                        nmiss_reg <= nmiss_inc[7:0];
                end
                S_DIV:
                    st_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (dv_done)
                    begin
                        if (div_pedal_reg)
                        begin
                            pmean_reg <= TB'(dv_q);
                            st_reg    <= S_OUT;
                        end
                        else
                        begin
                            nmean_reg <= TB'(dv_q);
                            st_reg    <= S_OUT;
                            if (ov_reg)
                            begin
                                ov_reg <= 1'b0;
                                if (nent_reg > CB'(FOLD_MIN_COUNT))
                                    st_reg <= S_F0;
                            end
                        end
                    end
                end
                S_F0:
                begin
                    plo_reg <= mul_p;
                    st_reg  <= S_F1;
                end
                S_F1:
                begin
                    phi_reg <= mul_p;
                    st_reg  <= S_FJ;
                end
                S_FJ:
                begin
                    st_reg <= S_OUT;
                    if (pp > plo_reg && pp < phi_reg)
                    begin
                        if (nent_reg[0])
                        begin
                            ntot_reg <= (ntot_reg > SB'(rec0_reg)) ?
                                        ntot_reg - SB'(rec0_reg) : '0;
                            rec0_reg <= f12_w[TB] ? TMAX : f12_w[TB-1:0];
                        end
                        else
                            rec0_reg <= f01_w[TB] ? TMAX : f01_w[TB-1:0];
                        rec1_reg <= '0;
                        rec2_reg <= '0;
                        nent_reg <= nent_reg >> 1;
                        if ((nent_reg >> 1) == '0)
                            nmean_reg <= '0;
                        else
                        begin
                            div_pedal_reg <= 1'b0;
                            st_reg        <= S_DIV;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        st_reg <= S_IDLE;
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    assign note_period  = nmean_reg;
    assign pedal_period = pmean_reg;
    assign note_count   = nent_reg;
    assign event_use    = use_reg;

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dv_busy |-> (st_reg == S_DWAIT)) else $error("divider busy outside wait");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> in_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pent_reg == '0) |-> (pmean_reg == '0)) else $error("pedal mean");
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the MIDI tempo tracker
// Random and directed MIDI events with gaps on both sides; an in-bench tempo
// predictor computes every result and the monitor compares each transfer.
// ============================================================================
module tb;

    localparam int TB = 24;
    localparam int CB = 16;
    localparam int FOLD_MIN = 8;
    localparam int HOLD_CYCLES = 400;
    localparam logic [63:0] TMAX = (64'd1 << TB) - 1;
    localparam logic [63:0] CMAX = (64'd1 << CB) - 1;
    localparam logic [63:0] TOTMAX = (64'd1 << (TB + CB)) - 1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  ctrl;
        logic [6:0]  val;
        logic [23:0] delta;
    } midi_event_t;

    typedef struct packed {
        logic [23:0] note_p;
        logic [23:0] pedal_p;
        logic [15:0] count;
        logic [1:0]  use_code;
    } tempo_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] event_kind;
    logic [6:0] controller, ctrl_value;
    logic [23:0] delta_time, note_period, pedal_period;
    logic [15:0] note_count;
    logic [1:0] event_use;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;

    midi_tempo_tracker dut (.*);

    // pending events, expected tempo results
    midi_event_t event_q[$];
    tempo_t tempo_q[$];
    int errors = 0;

    // long receiver hold-off, counted in its own process
    bit hold_go = 0;
    bit hold_done = 0;
    int hold_cnt = 0;
    logic holding;
    assign holding = hold_go && !hold_done;

    // predictor state
    logic [63:0] r_min_gap, r_lower, r_upper, r_nlim, r_plim;
    bit first_note, first_pedal;
    logic [63:0] n_gap, p_gap, n_tot, n_cnt, n_mean, half_iv, n_miss;
    logic [63:0] recent[3];
    logic [63:0] p_tot, p_cnt, p_mean, p_miss;

    function automatic logic [63:0] sat(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [63:0] s;
        s = a + b;
        return (s > m) ? m : s;
    endfunction

    function automatic bit in_win(logic [63:0] v, logic [63:0] m);
        return (v * 64'd256 > m * r_lower) && (v * 64'd256 < m * r_upper);
    endfunction

    function automatic void note_push(logic [63:0] v);
        recent[2] = recent[1];
        recent[1] = recent[0];
        recent[0] = v;
        n_tot = sat(n_tot, v, TOTMAX);
        n_cnt = sat(n_cnt, 64'd1, CMAX);
        n_mean = n_tot / n_cnt;
        n_miss = 0;
    endfunction

    function automatic void note_judge(logic [63:0] d);
        logic [63:0] p, nw, m;
        if (n_cnt == 0 || in_win(d, n_mean))
        begin
            note_push(d);
            p = p_mean * 64'd256;
            // eighth notes against the pedal beat: fold pairs into quarters
            if (n_cnt > FOLD_MIN && p > 64'd8 * r_lower * n_mean
                    && p < 64'd8 * r_upper * n_mean)
            begin
                if (n_cnt[0])
                begin
                    n_tot = (n_tot > recent[0]) ? n_tot - recent[0] : 64'd0;
                    nw = sat(recent[1], recent[2], TMAX);
                end
                else
                    nw = sat(recent[0], recent[1], TMAX);
                n_cnt = n_cnt >> 1;
                recent[0] = nw;
                recent[1] = 0;
                recent[2] = 0;
                n_mean = (n_cnt != 0) ? n_tot / n_cnt : 64'd0;
            end
        end
        else if (in_win(64'd2 * d, n_mean))
        begin
            if (half_iv == 0)
                half_iv = d;
            else
            begin
                note_push(sat(half_iv, d, TMAX));
                half_iv = 0;
            end
        end
        else
        begin
            m = n_miss + 64'd1;
            if (m > r_nlim)
            begin
                n_cnt = 0; n_tot = 0; n_mean = 0; m = 0;
            end
            n_miss = m;
        end
    endfunction

    function automatic void pedal_judge(logic [63:0] d);
        logic [63:0] m;
        if (p_cnt == 0 || in_win(d, p_mean))
        begin
            p_tot = sat(p_tot, d, TOTMAX);
            p_cnt = sat(p_cnt, 64'd1, CMAX);
            p_mean = p_tot / p_cnt;
            p_miss = 0;
        end
        else
        begin
            m = p_miss + 64'd1;
            if (m > r_plim)
            begin
                p_cnt = 0; p_tot = 0; p_mean = 0; m = 0;
            end
            p_miss = m;
        end
    endfunction

    function automatic tempo_t predict_tempo(midi_event_t e);
        tempo_t r;
        bit is_note, is_pedal;
        logic [1:0] u;
        is_note = e.kind == mtt_pkg::KIND_NOTE;
        is_pedal = e.kind == mtt_pkg::KIND_CC && e.ctrl == mtt_pkg::PEDAL_CONTROLLER
                   && e.val == mtt_pkg::PEDAL_PRESSED;
        u = mtt_pkg::USE_IGNORED;
        if (first_note && is_note)
        begin
            first_note = 0;
            u = mtt_pkg::USE_FIRST;
        end
        else if (first_pedal && is_pedal)
        begin
            first_pedal = 0;
            u = mtt_pkg::USE_FIRST;
        end
        else
        begin
            if (!first_note) n_gap = sat(n_gap, 64'(e.delta), TMAX);
            if (!first_pedal) p_gap = sat(p_gap, 64'(e.delta), TMAX);
            if (is_note && n_gap > r_min_gap)
            begin
                note_judge(n_gap);
                n_gap = 0;
                u = mtt_pkg::USE_NOTE;
            end
            else if (is_pedal)
            begin
                pedal_judge(p_gap);
                p_gap = 0;
                u = mtt_pkg::USE_PEDAL;
            end
        end
        r.note_p = n_mean[23:0];
        r.pedal_p = p_mean[23:0];
        r.count = n_cnt[15:0];
        r.use_code = u;
        return r;
    endfunction

    // gap length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------
    // clock, limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // hold-off counter
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (holding)
        begin
            if (hold_cnt < HOLD_CYCLES)
                hold_cnt++;
            else
                hold_done = 1;
        end
    end

    // ------------------------------------------------------------------
    // driver: predicts at transfer so predictor order follows the block
    // ------------------------------------------------------------------
    int in_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        tempo_t exp_t;
        midi_event_t sent;
        if (!rst_n)
        begin
            in_valid <= 0;
            event_kind <= 0;
            controller <= 0;
            ctrl_value <= 0;
            delta_time <= 0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sent = event_q.pop_front();
                exp_t = predict_tempo(sent);
                tempo_q = {tempo_q, exp_t};
                in_gap = gap_len();
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 0;
                end
                else if (event_q.size() > 0)
                begin
                    in_valid <= 1;
                    event_kind <= event_q[0].kind;
                    controller <= event_q[0].ctrl;
                    ctrl_value <= event_q[0].val;
                    delta_time <= event_q[0].delta;
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and receiver stall
    // ------------------------------------------------------------------
    int out_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        tempo_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (tempo_q.size() == 0)
                begin
                    $display("%t: unexpected result use=%0d", $realtime, event_use);
                    errors++;
                end
                else
                begin
                    exp_r = tempo_q.pop_front();
                    if (exp_r != {note_period, pedal_period, note_count, event_use})
                    begin
                        $display("%t: mismatch exp np=%0d pp=%0d cnt=%0d use=%0d",
                                 $realtime, exp_r.note_p, exp_r.pedal_p, exp_r.count,
                                 exp_r.use_code);
                        $display("%t:          got np=%0d pp=%0d cnt=%0d use=%0d",
                                 $realtime, note_period, pedal_period, note_count,
                                 event_use);
                        errors++;
                    end
                end
                out_gap = gap_len();
            end
            if (holding)
                out_stall <= 1;
            else if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1;
            end
            else
                out_stall <= 0;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_ev(logic [1:0] k, logic [6:0] c, logic [6:0] v, logic [23:0] d);
        midi_event_t e;
        e.kind = k; e.ctrl = c; e.val = v; e.delta = d;
        event_q = {event_q, e};
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            mtt_pkg::REG_MIN_GAP:     r_min_gap = 64'(data);
            mtt_pkg::REG_LOWER:       r_lower = 64'(data[11:0]);
            mtt_pkg::REG_UPPER:       r_upper = 64'(data[11:0]);
            mtt_pkg::REG_NOTE_LIMIT:  r_nlim = 64'(data[7:0]);
            mtt_pkg::REG_PEDAL_LIMIT: r_plim = 64'(data[7:0]);
            default: ;
        endcase
    endtask

    // drain and let the block settle before reconfiguring
    task automatic drain();
        while (event_q.size() > 0 || tempo_q.size() > 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // musical phrase: notes near a beat, pedal every few beats, some noise
    task automatic phrase(int n, int beat);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                add_ev(mtt_pkg::KIND_NOTE, 7'($urandom), 7'($urandom),
                       24'(beat + $urandom_range(0, beat / 8) - beat / 16));
            else if (r < 60)
                add_ev(mtt_pkg::KIND_NOTE, 7'($urandom), 7'($urandom), 24'(beat / 2));
            else if (r < 72)
                add_ev(mtt_pkg::KIND_CC, mtt_pkg::PEDAL_CONTROLLER, mtt_pkg::PEDAL_PRESSED,
                       24'(beat + $urandom_range(0, beat / 10)));
            else if (r < 80)
                add_ev(mtt_pkg::KIND_CC,
                       $urandom_range(0, 1) ? mtt_pkg::PEDAL_CONTROLLER : 7'($urandom),
                       7'($urandom), 24'($urandom_range(0, 40)));
            else if (r < 88)
                add_ev(2'($urandom), 7'($urandom), 7'($urandom), 24'($urandom_range(0, 30)));
            else if (r < 95)
                add_ev(mtt_pkg::KIND_NOTE, 7'($urandom), 7'($urandom),
                       24'($urandom_range(0, 4 * beat)));
            else
                add_ev(2'($urandom), 7'($urandom), 7'($urandom), 24'($urandom));
        end
    endtask

    initial
    begin
        int beat;
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = 0; cfg_data = 0;
        r_min_gap = 0; r_lower = 205; r_upper = 307; r_nlim = 10; r_plim = 2;
        first_note = 1; first_pedal = 1;
        n_gap = 0; p_gap = 0; n_tot = 0; n_cnt = 0; n_mean = 0; half_iv = 0;
        n_miss = 0; recent = '{0, 0, 0};
        p_tot = 0; p_cnt = 0; p_mean = 0; p_miss = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // directed: first events, extremes, kind 3, half intervals, saturation
        add_ev(mtt_pkg::KIND_CC, mtt_pkg::PEDAL_CONTROLLER, mtt_pkg::PEDAL_PRESSED, 24'd5);
        add_ev(mtt_pkg::KIND_NOTE, 7'd127, 7'd127, 24'hFFFFFF);
        add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, 24'd0);
        add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, 24'd480);
        add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, 24'd480);
        add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, 24'd240);
        add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, 24'd240);
        add_ev(2'd3, 7'd64, 7'd127, 24'd100);
        add_ev(mtt_pkg::KIND_OTHER, 7'd127, 7'd0, 24'd7);
        add_ev(mtt_pkg::KIND_CC, mtt_pkg::PEDAL_CONTROLLER, 7'd126, 24'd1);
        add_ev(mtt_pkg::KIND_CC, 7'd65, mtt_pkg::PEDAL_PRESSED, 24'd1);
        add_ev(mtt_pkg::KIND_CC, mtt_pkg::PEDAL_CONTROLLER, mtt_pkg::PEDAL_PRESSED, 24'd1900);
        add_ev(mtt_pkg::KIND_CC, mtt_pkg::PEDAL_CONTROLLER, mtt_pkg::PEDAL_PRESSED, 24'd1920);
        add_ev(mtt_pkg::KIND_CC, mtt_pkg::PEDAL_CONTROLLER, mtt_pkg::PEDAL_PRESSED, 24'd50);
        add_ev(mtt_pkg::KIND_OTHER, 7'd0, 7'd0, 24'hFFFFFF);
        add_ev(mtt_pkg::KIND_OTHER, 7'd0, 7'd0, 24'hFFFFFF);
        add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, 24'hFFFFFF);
        add_ev(mtt_pkg::KIND_CC, mtt_pkg::PEDAL_CONTROLLER, mtt_pkg::PEDAL_PRESSED,
               24'hFFFFFF);
        for (int i = 0; i < 5; i++) add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, 24'd3);
        drain();

        // phase 1: reset settings, receiver holds off long while items pile up
        hold_go = 1;
        phrase(150, 480);
        drain();

        // phase 2: eighth notes under a pedal beat to trigger folding
        for (int i = 0; i < 12; i++)
            add_ev(mtt_pkg::KIND_CC, mtt_pkg::PEDAL_CONTROLLER, mtt_pkg::PEDAL_PRESSED,
                   24'd8);
        for (int i = 0; i < 200; i++)
            if ($urandom_range(0, 7) == 0)
                add_ev(mtt_pkg::KIND_CC, mtt_pkg::PEDAL_CONTROLLER, mtt_pkg::PEDAL_PRESSED,
                       24'(60 + $urandom_range(0, 3)));
            else
                add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, 24'(60 + $urandom_range(0, 3)));
        phrase(100, 64);
        drain();

        // phase 3: extremes of every register
        cfg_write(mtt_pkg::REG_MIN_GAP, 24'hFFFFFF);
        cfg_write(mtt_pkg::REG_LOWER, 24'd0);
        cfg_write(mtt_pkg::REG_UPPER, 24'hFFF);
        cfg_write(mtt_pkg::REG_NOTE_LIMIT, 24'd255);
        cfg_write(mtt_pkg::REG_PEDAL_LIMIT, 24'd0);
        phrase(150, 1 << 22);
        drain();

        cfg_write(mtt_pkg::REG_MIN_GAP, 24'd0);
        cfg_write(mtt_pkg::REG_LOWER, 24'hFFF);
        cfg_write(mtt_pkg::REG_UPPER, 24'd0);
        cfg_write(mtt_pkg::REG_NOTE_LIMIT, 24'd0);
        cfg_write(mtt_pkg::REG_PEDAL_LIMIT, 24'd255);
        phrase(120, 200);
        drain();

        // note miss limit 255: misses at 5000 alternate with notes at 1000
        cfg_write(mtt_pkg::REG_LOWER, 24'd240);
        cfg_write(mtt_pkg::REG_UPPER, 24'd272);
        cfg_write(mtt_pkg::REG_NOTE_LIMIT, 24'd255);
        add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, 24'd1000);
        for (int i = 0; i < 260; i++)
            add_ev(mtt_pkg::KIND_NOTE, 7'd0, 7'd0, i[0] ? 24'd5000 : 24'd1000);
        drain();

        // remaining random phases with random settings
        for (int ph = 0; ph < 3; ph++)
        begin
            cfg_write(mtt_pkg::REG_MIN_GAP,
                      24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : 0));
            cfg_write(mtt_pkg::REG_LOWER, 24'($urandom_range(150, 240)));
            cfg_write(mtt_pkg::REG_UPPER, 24'($urandom_range(270, 400)));
            cfg_write(mtt_pkg::REG_NOTE_LIMIT, 24'($urandom_range(0, 12)));
            cfg_write(mtt_pkg::REG_PEDAL_LIMIT, 24'($urandom_range(0, 4)));
            beat = $urandom_range(20, 5000);
            phrase(150, beat);
            drain();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
